// ===== hdl/quadrature_encoder_with_button_macros.svh =====
// Assertion helpers shared by the encoder block.
`ifndef QUADRATURE_ENCODER_WITH_BUTTON_MACROS_SVH
`define QUADRATURE_ENCODER_WITH_BUTTON_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QEB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qeb assertion failed");

// Next-cycle implication, disabled during reset.
`define QEB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qeb assertion failed");

`endif

// ===== hdl/qeb_pkg.sv =====
package qeb_pkg;

  // Request commands
  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_READ_ROT   = 2'd1,
    CMD_READ_PRESS = 2'd2,
    CMD_READ_LONG  = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_BTN_EN     = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  // Encoder phase transition
  typedef enum logic [1:0] {
    MOVE_NONE,
    MOVE_UP,
    MOVE_DOWN
  } move_t;

  localparam int TIME_W      = 32;
  localparam int MS_W        = 16;
  localparam int STEP_W      = 16;
  localparam int CNT_W       = 8;
  localparam int REPLY_W     = 15;
  localparam int DIV_STEPS   = TIME_W;
  localparam int DIV_COUNT_W = $clog2(DIV_STEPS);

  localparam logic [MS_W-1:0]   DEBOUNCE_RESET   = 16'd50;
  localparam logic [MS_W-1:0]   LONG_PRESS_RESET = 16'd1000;
  localparam logic [1:0]        PHASE_RESET      = 2'd3;
  localparam logic signed [STEP_W-1:0] STEP_MAX  = 16'sh7FFF;
  localparam logic signed [STEP_W-1:0] STEP_MIN  = 16'sh8000;
  localparam logic signed [STEP_W-1:0] STEP_READ_MIN = 16'sd4;
  localparam logic [CNT_W-1:0]  CNT_MAX          = 8'hFF;

  // Gray-code step direction between two phase pairs {A,B}
  function automatic move_t phase_move(input logic [1:0] from, input logic [1:0] to);
    move_t m;
    m = MOVE_NONE;
    case ({from, to})
      4'b11_10, 4'b00_01, 4'b01_11, 4'b10_00: m = MOVE_UP;
      4'b11_01, 4'b00_10, 4'b01_00, 4'b10_11: m = MOVE_DOWN;
      default:                                m = MOVE_NONE;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/quadrature_encoder_with_button.sv =====
// Quadrature encoder (x4) decoder with a debounced push button.
//
// Request channel: req_valid / req_stall carry command, enc_a, enc_b,
// btn_level and now_ms. Command 0 is a sample tick; 1 reads rotation;
// 2 and 3 read and clear the press and long-press counts.
// Response channel: rsp_valid / rsp_stall carry reply_value and
// button_held, exactly one response per request, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 debounce ms, 1 long-press ms, 2 button enable), which the user
// must do only while idle; the block itself does not enforce this.
// Timing: a plain request goes from S_IDLE to S_DONE, where its response
// is registered on commit; the next request is taken once the sequencer
// is back in S_IDLE. A sample tick with the button enabled and a hold
// longer than the long-press time runs a radix-2 restoring divider for
// the long-press count in S_DIV, one quotient bit per cycle for the 32
// bits of the elapsed time. The output register lets the next request
// start while a response waits; a stalled receiver holds the finished
// result and the sequencer waits to commit the following one.
// Reset (synchronous, active high) restores the register defaults and
// clears all counters; no response is pending after reset.
`include "quadrature_encoder_with_button_macros.svh"

module quadrature_encoder_with_button (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  command,
  input  logic        enc_a,
  input  logic        enc_b,
  input  logic        btn_level,
  input  logic [31:0] now_ms,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [14:0] reply_value,
  output logic        button_held,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [qeb_pkg::MS_W-1:0] debounce_ms;
  logic [qeb_pkg::MS_W-1:0] long_press_ms;
  logic                     button_enabled;

  // Block state
  qeb_pkg::state_t state, state_next;
  logic [1:0]                        enc_phase, enc_phase_next;
  logic signed [qeb_pkg::STEP_W-1:0] step_count, step_count_next;
  logic                              button_state, button_state_next;
  logic [qeb_pkg::CNT_W-1:0]         press_count, press_count_next;
  logic [qeb_pkg::CNT_W-1:0]         long_count, long_count_next;
  logic [qeb_pkg::TIME_W-1:0]        hold_start, hold_start_next;
  logic                              hold_active, hold_active_next;
  logic [qeb_pkg::TIME_W-1:0]        last_change, last_change_next;

  // Latched request
  qeb_pkg::cmd_t              cmd_q;
  logic [1:0]                 enc_q;
  logic                       lvl_q;
  logic [qeb_pkg::TIME_W-1:0] now_q;
  logic                       long_upd;

  // Divider
  logic [qeb_pkg::MS_W-1:0]        div_unit;
  logic [qeb_pkg::MS_W-1:0]        div_rem, div_rem_next;
  logic [qeb_pkg::TIME_W-1:0]      div_quo, div_quo_next;
  logic [qeb_pkg::DIV_COUNT_W-1:0] div_count, div_count_next;

  // Response register
  logic                        rsp_valid_next;
  logic [qeb_pkg::REPLY_W-1:0] reply_next;
  logic                        held_next;
  logic                        commit;

  logic                       req_take;
  logic [qeb_pkg::TIME_W-1:0] hold_elapsed;
  logic                       long_due;

  assign req_stall = (state != qeb_pkg::S_IDLE);
  assign req_take  = req_valid && !req_stall;

  // Zero long-press time acts as one
  assign div_unit = (long_press_ms == '0) ? qeb_pkg::MS_W'(1) : long_press_ms;

  // Long-press due check on the incoming tick
  assign hold_elapsed = now_ms - hold_start;
  assign long_due = (qeb_pkg::cmd_t'(command) == qeb_pkg::CMD_TICK) && button_enabled &&
                    hold_active && (hold_elapsed > {16'd0, div_unit});

  assign commit = (state == qeb_pkg::S_DONE) && (!rsp_valid || !rsp_stall);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms    <= qeb_pkg::DEBOUNCE_RESET;
      long_press_ms  <= qeb_pkg::LONG_PRESS_RESET;
      button_enabled <= 1'b1;
    end else if (cfg_we) begin
      case (qeb_pkg::cfg_idx_t'(cfg_index))
        qeb_pkg::CFG_DEBOUNCE:   debounce_ms    <= cfg_data;
        qeb_pkg::CFG_LONG_PRESS: long_press_ms  <= cfg_data;
        qeb_pkg::CFG_BTN_EN:     button_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (req_take) begin
      cmd_q    <= qeb_pkg::cmd_t'(command);
      enc_q    <= {enc_a, enc_b};
      lvl_q    <= btn_level;
      now_q    <= now_ms;
      long_upd <= long_due;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= qeb_pkg::S_IDLE;
      rsp_valid    <= 1'b0;
      enc_phase    <= qeb_pkg::PHASE_RESET;
      step_count   <= '0;
      button_state <= 1'b1;
      press_count  <= '0;
      long_count   <= '0;
      hold_start   <= '0;
      hold_active  <= 1'b0;
      last_change  <= '0;
    end else begin
      state        <= state_next;
      rsp_valid    <= rsp_valid_next;
      enc_phase    <= enc_phase_next;
      step_count   <= step_count_next;
      button_state <= button_state_next;
      press_count  <= press_count_next;
      long_count   <= long_count_next;
      hold_start   <= hold_start_next;
      hold_active  <= hold_active_next;
      last_change  <= last_change_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    div_rem   <= div_rem_next;
    div_quo   <= div_quo_next;
    div_count <= div_count_next;
    if (commit) begin
      reply_value <= reply_next;
      button_held <= held_next;
    end
  end

  // Sequencer, divider step and state update
  always_comb begin
    logic [qeb_pkg::MS_W:0]     rem_shift;
    logic [qeb_pkg::TIME_W-1:0] since_change;
    qeb_pkg::move_t             move;

    state_next        = state;
    enc_phase_next    = enc_phase;
    step_count_next   = step_count;
    button_state_next = button_state;
    press_count_next  = press_count;
    long_count_next   = long_count;
    hold_start_next   = hold_start;
    hold_active_next  = hold_active;
    last_change_next  = last_change;
    div_rem_next      = div_rem;
    div_quo_next      = div_quo;
    div_count_next    = div_count;
    reply_next        = '0;
    rsp_valid_next    = rsp_valid && rsp_stall;
    rem_shift         = {div_rem, div_quo[qeb_pkg::TIME_W-1]};
    since_change      = now_q - last_change;
    move              = qeb_pkg::phase_move(enc_phase, enc_q);

    case (state)
      qeb_pkg::S_IDLE: begin
        if (req_take) begin
          div_rem_next   = '0;
          div_quo_next   = hold_elapsed;
          div_count_next = '0;
          state_next     = long_due ? qeb_pkg::S_DIV : qeb_pkg::S_DONE;
        end
      end

      // one restoring-division step per cycle
      qeb_pkg::S_DIV: begin
        if (rem_shift >= {1'b0, div_unit}) begin
          div_rem_next = qeb_pkg::MS_W'(rem_shift - {1'b0, div_unit});
          div_quo_next = {div_quo[qeb_pkg::TIME_W-2:0], 1'b1};
        end else begin
          div_rem_next = rem_shift[qeb_pkg::MS_W-1:0];
          div_quo_next = {div_quo[qeb_pkg::TIME_W-2:0], 1'b0};
        end
        div_count_next = div_count + 1'b1;
        if (div_count == qeb_pkg::DIV_COUNT_W'(qeb_pkg::DIV_STEPS - 1)) begin
          state_next = qeb_pkg::S_DONE;
        end
      end

      qeb_pkg::S_DONE: begin
        if (commit) begin
          rsp_valid_next = 1'b1;
          state_next     = qeb_pkg::S_IDLE;
          case (cmd_q)
            qeb_pkg::CMD_TICK: begin
              // long-press count from the quotient, saturated
              if (long_upd) begin
                long_count_next = (div_quo[qeb_pkg::TIME_W-1:qeb_pkg::CNT_W] != '0) ?
                                  qeb_pkg::CNT_MAX : div_quo[qeb_pkg::CNT_W-1:0];
              end
              // debounced button edge
              if (button_enabled && (lvl_q != button_state) &&
                  (since_change > {16'd0, debounce_ms})) begin
                button_state_next = lvl_q;
                if (!lvl_q) begin
                  if (press_count != qeb_pkg::CNT_MAX) begin
                    press_count_next = press_count + 1'b1;
                  end
                  hold_active_next = 1'b1;
                  hold_start_next  = now_q;
                end else begin
                  hold_active_next = 1'b0;
                end
                last_change_next = now_q;
              end
              // encoder step, saturating
              if (enc_q != enc_phase) begin
                if (move == qeb_pkg::MOVE_UP && step_count != qeb_pkg::STEP_MAX) begin
                  step_count_next = step_count + 16'sd1;
                end else if (move == qeb_pkg::MOVE_DOWN &&
                             step_count != qeb_pkg::STEP_MIN) begin
                  step_count_next = step_count - 16'sd1;
                end
                enc_phase_next = enc_q;
              end
            end
            qeb_pkg::CMD_READ_ROT: begin
              if (step_count >= qeb_pkg::STEP_READ_MIN) begin
                step_count_next = step_count >>> 2;
                reply_next      = qeb_pkg::REPLY_W'(step_count >>> 2);
              end
            end
            qeb_pkg::CMD_READ_PRESS: begin
              reply_next       = qeb_pkg::REPLY_W'(press_count);
              press_count_next = '0;
            end
            qeb_pkg::CMD_READ_LONG: begin
              reply_next      = qeb_pkg::REPLY_W'(long_count);
              long_count_next = '0;
              if (button_enabled && !button_state) begin
                hold_active_next = 1'b1;
                hold_start_next  = now_q;
              end else begin
                hold_active_next = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      default: state_next = qeb_pkg::S_IDLE;
    endcase

    held_next = hold_active_next && button_enabled;
  end

  // Checks
  `QEB_ASSERT_NEXT(a_busy_after_take, clk, rst, req_take, req_stall)
  `QEB_ASSERT_NEXT(a_div_ends, clk, rst,
    (state == qeb_pkg::S_DIV) &&
    (div_count == qeb_pkg::DIV_COUNT_W'(qeb_pkg::DIV_STEPS - 1)),
    state == qeb_pkg::S_DONE)
  `QEB_ASSERT_NEXT(a_wait_on_stall, clk, rst,
    (state == qeb_pkg::S_DONE) && rsp_valid && rsp_stall,
    (state == qeb_pkg::S_DONE) && rsp_valid)
  `QEB_ASSERT_SAME(a_rem_below_unit, clk, rst, state == qeb_pkg::S_DIV, div_rem < div_unit)

endmodule

// ===== tb/qeb_checker.sv =====
// Watches the request, response and register ports of the encoder block,
// predicts each response and compares it with what the block returns.
module qeb_checker
  import qeb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic [1:0]  command,
  input  logic        enc_a,
  input  logic        enc_b,
  input  logic        btn_level,
  input  logic [31:0] now_ms,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic [14:0] reply_value,
  input  logic        button_held,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          responses
);

  typedef struct packed {
    logic [REPLY_W-1:0] value;
    logic               held;
  } reply_t;

  // Shadow registers
  logic [MS_W-1:0] db_ms;
  logic [MS_W-1:0] lp_ms;
  logic            btn_en;

  // Shadow block state
  logic [1:0]               enc_phase;
  logic signed [STEP_W-1:0] rot_count;
  logic                     btn_lvl;
  logic [CNT_W-1:0]         press_cnt;
  logic [CNT_W-1:0]         long_cnt;
  logic [TIME_W-1:0]        hold_t0;
  logic                     holding;
  logic [TIME_W-1:0]        last_edge_t;

  reply_t reply_q[$];
  reply_t exp_r;
  int     err_cnt;
  int     rsp_cnt;

  initial begin
    mismatches = 0;
    pending    = 0;
    responses  = 0;
    err_cnt    = 0;
    rsp_cnt    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    err_cnt++;
  endtask

  // Apply one request to the shadow state and queue its expected response
  task automatic predict_reply(input cmd_t cmd, input logic a, input logic b,
                               input logic lvl, input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] unit;
    logic [TIME_W-1:0] quo;
    logic [1:0]        np;
    reply_t            r;
    r.value = '0;
    case (cmd)
      CMD_TICK: begin
        // long-press timing runs before the button is sampled
        if (btn_en && holding) begin
          elapsed = now - hold_t0;
          unit = (lp_ms == '0) ? 32'd1 : {16'd0, lp_ms};
          if (elapsed > unit) begin
            quo = elapsed / unit;
            long_cnt = (quo > 32'd255) ? CNT_MAX : quo[CNT_W-1:0];
          end
        end
        // debounced button edge
        if (btn_en && lvl != btn_lvl && (now - last_edge_t) > {16'd0, db_ms}) begin
          btn_lvl = lvl;
          if (!lvl) begin
            if (press_cnt != CNT_MAX) press_cnt = press_cnt + 8'd1;
            holding = 1'b1;
            hold_t0 = now;
          end else begin
            holding = 1'b0;
          end
          last_edge_t = now;
        end
        // Gray-code step; a diagonal jump only moves the phase
        np = {a, b};
        if (np != enc_phase) begin
          if (np == {enc_phase[0], ~enc_phase[1]}) begin
            if (rot_count != STEP_MAX) rot_count = rot_count + 16'sd1;
          end else if (np == {~enc_phase[0], enc_phase[1]}) begin
            if (rot_count != STEP_MIN) rot_count = rot_count - 16'sd1;
          end
          enc_phase = np;
        end
      end
      CMD_READ_ROT: begin
        if (rot_count >= STEP_READ_MIN) begin
          rot_count = rot_count >>> 2;
          r.value = rot_count[REPLY_W-1:0];
        end
      end
      CMD_READ_PRESS: begin
        r.value = {7'd0, press_cnt};
        press_cnt = '0;
      end
      default: begin
        r.value = {7'd0, long_cnt};
        long_cnt = '0;
        // hold restarts only while the accepted level is pressed
        if (btn_en && !btn_lvl) begin
          holding = 1'b1;
          hold_t0 = now;
        end else begin
          holding = 1'b0;
        end
      end
    endcase
    r.held = holding & btn_en;
    reply_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      db_ms       = DEBOUNCE_RESET;
      lp_ms       = LONG_PRESS_RESET;
      btn_en      = 1'b1;
      enc_phase   = PHASE_RESET;
      rot_count   = '0;
      btn_lvl     = 1'b1;
      press_cnt   = '0;
      long_cnt    = '0;
      hold_t0     = '0;
      holding     = 1'b0;
      last_edge_t = '0;
      reply_q.delete();
      err_cnt     = 0;
      rsp_cnt     = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DEBOUNCE:   db_ms = cfg_data;
          CFG_LONG_PRESS: lp_ms = cfg_data;
          CFG_BTN_EN:     btn_en = cfg_data[0];
          default: ;
        endcase
      end
      // responses are matched before new requests are queued
      if (rsp_valid && !rsp_stall) begin
        rsp_cnt++;
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("unexpected response value=%0d held=%0b",
                                    reply_value, button_held));
        end else begin
          exp_r = reply_q.pop_front();
          if (reply_value !== exp_r.value)
            report_mismatch($sformatf("response %0d: reply_value %0d, expected %0d",
                                      rsp_cnt, reply_value, exp_r.value));
          if (button_held !== exp_r.held)
            report_mismatch($sformatf("response %0d: button_held %0b, expected %0b",
                                      rsp_cnt, button_held, exp_r.held));
        end
      end
      if (req_valid && !req_stall)
        predict_reply(cmd_t'(command), enc_a, enc_b, btn_level, now_ms);
    end
    mismatches <= err_cnt;
    pending    <= reply_q.size();
    responses  <= rsp_cnt;
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import qeb_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  command = CMD_TICK;
  logic        enc_a = 1'b1;
  logic        enc_b = 1'b1;
  logic        btn_level = 1'b1;
  logic [31:0] now_ms = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [14:0] reply_value;
  logic        button_held;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_DEBOUNCE;
  logic [15:0] cfg_data = '0;

  int mismatches;
  int pending;
  int responses;

  // Stimulus bookkeeping
  int          n_sent = 0;
  int          n_settings = 0;
  logic [31:0] cur_ms = '0;
  logic [1:0]  cur_ph = PHASE_RESET;
  logic        cur_lvl = 1'b1;
  int          cfg_db = 50;
  int          cfg_lp = 1000;

  // Receiver controls
  logic idle_on = 1'b1;
  logic hold_off_go = 1'b0;
  logic hold_off_used = 1'b0;
  int   hold_off_left = 0;

  always #1 clk = ~clk;

  quadrature_encoder_with_button u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .command     (command),
    .enc_a       (enc_a),
    .enc_b       (enc_b),
    .btn_level   (btn_level),
    .now_ms      (now_ms),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .reply_value (reply_value),
    .button_held (button_held),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  qeb_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .command     (command),
    .enc_a       (enc_a),
    .enc_b       (enc_b),
    .btn_level   (btn_level),
    .now_ms      (now_ms),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .reply_value (reply_value),
    .button_held (button_held),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .pending     (pending),
    .responses   (responses)
  );

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_go && !hold_off_used) begin
      hold_off_left <= 400;
      hold_off_used <= 1'b1;
    end
    rsp_stall <= (hold_off_left != 0) || (idle_on && $urandom_range(99) < 22);
  end

  // Offer one request and wait until it is taken
  task automatic send_req(input cmd_t cmd, input logic a, input logic b,
                          input logic lvl, input logic [31:0] now);
    while (idle_on && $urandom_range(99) < 22) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    command   <= cmd;
    enc_a     <= a;
    enc_b     <= b;
    btn_level <= lvl;
    now_ms    <= now;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic tick_at(input logic [1:0] ph, input logic lvl, input logic [31:0] now);
    cur_ms  = now;
    cur_ph  = ph;
    cur_lvl = lvl;
    send_req(CMD_TICK, ph[1], ph[0], lvl, now);
  endtask

  task automatic tick(input logic [1:0] ph, input logic lvl, input logic [31:0] dt);
    tick_at(ph, lvl, cur_ms + dt);
  endtask

  // Read requests carry junk in the unused fields
  task automatic read_cmd(input cmd_t cmd);
    send_req(cmd, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
             cur_ms);
  endtask

  task automatic spin(input int n, input bit fwd);
    repeat (n)
      tick(fwd ? {cur_ph[0], ~cur_ph[1]} : {~cur_ph[0], cur_ph[1]}, cur_lvl,
           $urandom_range(1));
  endtask

  // Stop offering and wait for every response
  task automatic drain();
    req_valid <= 1'b0;
    while (responses != n_sent) @(posedge clk);
  endtask

  task automatic load_config(input int db, input int lp, input logic en);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data  <= db[15:0];
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_data  <= lp[15:0];
    @(posedge clk);
    cfg_index <= CFG_BTN_EN;
    cfg_data  <= {15'd0, en};
    @(posedge clk);
    // unused index must be ignored
    cfg_index <= CFG_UNUSED;
    cfg_data  <= 16'($urandom_range(16'hFFFF));
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_db = db;
    cfg_lp = lp;
    n_settings++;
  endtask

  // Bounce, press, hold with some rotation, bounce, release
  task automatic press_sequence();
    int n;
    int hold_span;
    logic [1:0] ph;
    hold_span = cfg_lp / 2 + cfg_db + 2;
    repeat ($urandom_range(3)) tick(cur_ph, ~cur_lvl, $urandom_range(3));
    tick(cur_ph, 1'b0, $urandom_range(2 * cfg_db + 2));
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(9) == 0) begin
        read_cmd(CMD_READ_LONG);
      end else begin
        ph = ($urandom_range(9) < 3) ? {cur_ph[0], ~cur_ph[1]} : cur_ph;
        tick(ph, 1'b0, $urandom_range(hold_span));
      end
    end
    repeat ($urandom_range(2)) tick(cur_ph, ~cur_lvl, $urandom_range(3));
    tick(cur_ph, 1'b1, $urandom_range(2 * cfg_db + 2));
  endtask

  task automatic random_segment();
    int pick;
    int n;
    bit fwd;
    logic [1:0] ph;
    logic lvl;
    cmd_t cmd;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // rotation run with a little phase noise
      n = $urandom_range(1, 20);
      fwd = 1'($urandom_range(1));
      repeat (n) begin
        pick = $urandom_range(99);
        if (pick < 90) ph = fwd ? {cur_ph[0], ~cur_ph[1]} : {~cur_ph[0], cur_ph[1]};
        else if (pick < 95) ph = ~cur_ph;
        else ph = cur_ph;
        tick(ph, cur_lvl, $urandom_range(3));
      end
    end else if (pick < 65) begin
      press_sequence();
    end else if (pick < 85) begin
      read_cmd(cmd_t'($urandom_range(1, 3)));
    end else begin
      // fully random request, sometimes with a timestamp jump
      cmd = cmd_t'($urandom_range(3));
      ph  = 2'($urandom_range(3));
      lvl = 1'($urandom_range(1));
      if ($urandom_range(4) == 0) cur_ms = $urandom;
      else cur_ms = cur_ms + $urandom_range(2 * cfg_db + 2);
      if (cmd == CMD_TICK) begin
        cur_ph  = ph;
        cur_lvl = lvl;
      end
      send_req(cmd, ph[1], ph[0], lvl, cur_ms);
    end
  endtask

  task automatic run_random(input int n);
    int start;
    start = n_sent;
    while (n_sent - start < n) random_segment();
  endtask

  initial begin
    int db_set[6];
    int lp_set[6];
    logic en_set[6];
    db_set = '{50, 0, 65535, 10, 20, 0};
    lp_set = '{1000, 1, 65535, 0, 100, 1};
    en_set = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    db_set[5] = $urandom_range(200);
    lp_set[5] = $urandom_range(1, 500);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty reads, rotation, debounce, long press, wrap, saturation
    read_cmd(CMD_READ_ROT);
    read_cmd(CMD_READ_PRESS);
    read_cmd(CMD_READ_LONG);
    tick_at(2'b10, 1'b1, 32'd0);
    tick_at(2'b00, 1'b1, 32'd1);
    tick_at(2'b01, 1'b1, 32'd2);
    tick_at(2'b11, 1'b1, 32'd3);
    read_cmd(CMD_READ_ROT);
    tick_at(2'b01, 1'b1, 32'd4);            // backward step
    tick_at(2'b10, 1'b1, 32'd5);            // diagonal jump
    tick_at(2'b10, 1'b0, 32'd10);           // inside debounce window
    tick_at(2'b10, 1'b0, 32'd100);          // accepted press
    tick_at(2'b10, 1'b0, 32'd1100);         // exactly one unit, no update
    tick_at(2'b10, 1'b0, 32'd2101);
    read_cmd(CMD_READ_LONG);                // hold restarts while pressed
    tick_at(2'b10, 1'b1, 32'd2200);
    read_cmd(CMD_READ_PRESS);
    tick_at(2'b10, 1'b0, 32'hFFFF_FFF0);
    tick_at(2'b10, 1'b0, 32'h0000_0100);    // hold across timestamp wrap
    tick_at(2'b10, 1'b0, 32'h0000_1000);
    read_cmd(CMD_READ_LONG);
    load_config(50, 1, 1'b1);
    tick_at(2'b10, 1'b0, 32'h0000_3000);    // long count saturates
    read_cmd(CMD_READ_LONG);
    tick_at(2'b10, 1'b1, 32'h0000_3100);

    // Random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      load_config(db_set[p], lp_set[p], en_set[p]);
      if (p == 0) hold_off_go <= 1'b1;
      idle_on <= (p != 2);
      run_random(115);
    end
    idle_on <= 1'b1;

    // Press count saturation with no debounce
    load_config(0, 65535, 1'b1);
    repeat (520) tick(cur_ph, ~cur_lvl, 32'd1);
    read_cmd(CMD_READ_PRESS);

    // Rotation both ways, button off, no idling
    load_config(50, 1000, 1'b0);
    idle_on <= 1'b0;
    spin(40, 1'b1);
    read_cmd(CMD_READ_ROT);
    spin(60, 1'b0);
    read_cmd(CMD_READ_ROT);
    spin(10, 1'b1);
    read_cmd(CMD_READ_ROT);
    idle_on <= 1'b1;

    drain();
    repeat (40) @(posedge clk);

    $display("Ran %0d requests, %0d responses checked, %0d register settings.",
             n_sent, responses, n_settings);
    $display("Covered rotation both ways, press and long-press saturation, disabled button, wrap.");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
